### src/ir_camera_command_frame_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// IR camera frame encoder assertion macros
// Shared property forms for the checker of the frame encoder.
// ----------------------------------------------------------------------------
`ifndef IR_CAMERA_COMMAND_FRAME_ENCODER_UNIT_ASSERT_SVH
`define IR_CAMERA_COMMAND_FRAME_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define IRCF_ASSERT_IMP(label, clk, dis, ante, cons) \
	label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
		else $error("ircf check failed");

// next-cycle implication
`define IRCF_ASSERT_NXT(label, clk, dis, ante, cons) \
	label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
		else $error("ircf check failed");

`endif

### src/ircf_pkg.sv
// ----------------------------------------------------------------------------
// IR camera frame encoder package
// Frame constants, register map, pipeline types and the divider step.
// ----------------------------------------------------------------------------
package ircf_pkg;

	localparam int unsigned SIZE_W    = 12;
	localparam int unsigned DIV_BITS  = SIZE_W - 1;  // quotient bits of (size/2) / z
	localparam int unsigned Z_W       = 15;          // positive zoom factor
	localparam int unsigned LANES     = 4;
	localparam int unsigned FRAME_MAX = 16;
	localparam int unsigned BODY_MAX  = 13;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned BODY_W    = 4;

	localparam int unsigned LANE_X1 = 0;
	localparam int unsigned LANE_Y1 = 1;
	localparam int unsigned LANE_X2 = 2;
	localparam int unsigned LANE_Y2 = 3;

	localparam logic [7:0] FRAME_HEAD   = 8'hAA;
	localparam logic [7:0] FRAME_TAIL0  = 8'hEB;
	localparam logic [7:0] FRAME_TAIL1  = 8'hAA;
	localparam logic [7:0] FRAME_PREFIX = 8'h01;
	localparam logic [7:0] CMD_CORRECT  = 8'h11;
	localparam logic [7:0] CMD_BRIGHT   = 8'h23;
	localparam logic [7:0] CMD_ZOOM     = 8'h40;
	localparam logic [7:0] CMD_PALETTE  = 8'h42;
	localparam logic [7:0] LEN_SHORT    = 8'h05;
	localparam logic [7:0] LEN_BRIGHT   = 8'h06;
	localparam logic [7:0] LEN_ZOOM     = 8'h0C;
	localparam logic [7:0] OP_ONE       = 8'h01;
	localparam logic [7:0] OP_TWO       = 8'h02;

	localparam logic [BODY_W-1:0] BODY_SHORT  = 4'd6;
	localparam logic [BODY_W-1:0] BODY_BRIGHT = 4'd7;
	localparam logic [BODY_W-1:0] BODY_ZOOM   = 4'd13;
	localparam logic [CNT_W-1:0]  TAIL_BYTES  = 5'd3;

	localparam logic [2:0] MODE_CORRECT = 3'd0;
	localparam logic [2:0] MODE_BRIGHT  = 3'd1;
	localparam logic [2:0] MODE_OP_ONE  = 3'd2;
	localparam logic [2:0] MODE_OP_TWO  = 3'd3;
	localparam logic [2:0] MODE_PALETTE = 3'd4;
	localparam logic [2:0] MODE_ZOOM    = 3'd5;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd512;

	typedef struct packed {
		logic [2:0]        mode;
		logic [7:0]        cmd;
		logic [15:0]       value;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic              emit;
	} cmd_t;

	// dq holds the remaining dividend bits on top, quotient bits shift in below
	typedef struct packed {
		logic [Z_W-1:0]      rem;
		logic [DIV_BITS-1:0] dq;
	} div_lane_t;

	typedef div_lane_t [LANES-1:0] lanes_t;

	function automatic div_lane_t div_step(input div_lane_t l, input logic [Z_W-1:0] z);
		logic [Z_W:0] trial;
		logic [Z_W:0] diff;
		div_lane_t    r;
		trial = {l.rem, l.dq[DIV_BITS-1]};
		diff  = trial - {1'b0, z};
		if (trial >= {1'b0, z}) begin
			r.rem = diff[Z_W-1:0];
			r.dq  = {l.dq[DIV_BITS-2:0], 1'b1};
		end else begin
			r.rem = trial[Z_W-1:0];
			r.dq  = {l.dq[DIV_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

### src/ir_camera_command_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// IR camera command frame encoder
// Each accepted command request becomes one control frame sent out one byte
// per output request, the final byte flagged by last: AA, length, 01,
// command, operation, payload, byte-sum checksum, EB AA. Correction, operation
// and palette frames are 9 bytes, brightness 10, zoom 16; a zoom factor of 0
// or below and the undefined modes 6 and 7 produce nothing. A request passes
// through one input stage, an 11-stage restoring divider (one quotient bit
// per stage, four lanes for the zoom corners), a corner stage and a frame
// assembly stage before the serializer. Requests enter every cycle while the
// pipeline has room; the byte serializer at the output sends one byte per
// cycle while out_ready is high, and loads the next frame as the last byte
// of the previous one leaves; a request with no frame does not wait on it.
// image_width sits at byte address 0 and image_height at 4 (12 bits each).
// ----------------------------------------------------------------------------
module ir_camera_command_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// command request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  command_byte,
	input  logic signed [15:0] value,
	// frame byte channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned SIZE_W    = ircf_pkg::SIZE_W;
	localparam int unsigned DIV_BITS  = ircf_pkg::DIV_BITS;
	localparam int unsigned LANES     = ircf_pkg::LANES;
	localparam int unsigned FRAME_MAX = ircf_pkg::FRAME_MAX;
	localparam int unsigned BODY_MAX  = ircf_pkg::BODY_MAX;
	localparam int unsigned CNT_W     = ircf_pkg::CNT_W;
	localparam int unsigned BODY_W    = ircf_pkg::BODY_W;
	localparam int unsigned Z_W       = ircf_pkg::Z_W;
	localparam int unsigned SPLIT     = 7;

	// ---------------- configuration ----------------
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ircf_pkg::WIDTH_RST;
			height_q <= ircf_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				ircf_pkg::REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				ircf_pkg::REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			ircf_pkg::REG_WIDTH:  prdata[SIZE_W-1:0] = width_q;
			ircf_pkg::REG_HEIGHT: prdata[SIZE_W-1:0] = height_q;
			default: ;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic adv;      // whole pipeline moves one stage
	logic load_ok;  // serializer can take a frame this cycle
	logic pop;

	// ---------------- stage 1: capture ----------------
	logic           v_s1;
	ircf_pkg::cmd_t cmd_s1;
	logic           emit_in;

	assign emit_in = (mode < ircf_pkg::MODE_ZOOM) ||
		((mode == ircf_pkg::MODE_ZOOM) && !value[15] && (value != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			cmd_s1.mode  <= mode;
			cmd_s1.cmd   <= command_byte;
			cmd_s1.value <= value;
			cmd_s1.w     <= width_q;
			cmd_s1.h     <= height_q;
			cmd_s1.emit  <= emit_in;
		end
	end

	// dividends: floor(n / 2z) == floor(floor(n/2) / z)
	logic [SIZE_W-1:0]  wm1;
	logic [SIZE_W-1:0]  hm1;
	ircf_pkg::lanes_t   lanes0;

	always_comb begin
		wm1 = (cmd_s1.w == '0) ? '0 : cmd_s1.w - SIZE_W'(1);
		hm1 = (cmd_s1.h == '0) ? '0 : cmd_s1.h - SIZE_W'(1);
		for (int j = 0; j < LANES; j++) begin
			lanes0[j].rem = '0;
		end
		lanes0[ircf_pkg::LANE_X1].dq = cmd_s1.w[SIZE_W-1:1];
		lanes0[ircf_pkg::LANE_Y1].dq = cmd_s1.h[SIZE_W-1:1];
		lanes0[ircf_pkg::LANE_X2].dq = wm1[SIZE_W-1:1];
		lanes0[ircf_pkg::LANE_Y2].dq = hm1[SIZE_W-1:1];
	end

	// ---------------- divider stages ----------------
	logic             ds_v_in   [1:DIV_BITS];
	ircf_pkg::cmd_t   ds_cmd_in [1:DIV_BITS];
	ircf_pkg::lanes_t ds_ln_in  [1:DIV_BITS];
	logic             ds_v_sd   [1:DIV_BITS];
	ircf_pkg::cmd_t   ds_cmd_sd [1:DIV_BITS];
	ircf_pkg::lanes_t ds_ln_sd  [1:DIV_BITS];

	always_comb begin
		ds_v_in[1]   = v_s1;
		ds_cmd_in[1] = cmd_s1;
		ds_ln_in[1]  = lanes0;
		for (int k = 2; k <= DIV_BITS; k++) begin
			ds_v_in[k]   = ds_v_sd[k-1];
			ds_cmd_in[k] = ds_cmd_sd[k-1];
			ds_ln_in[k]  = ds_ln_sd[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_BITS; k++) begin
				ds_v_sd[k] <= 1'b0;
			end
		end else if (adv) begin
			for (int k = 1; k <= DIV_BITS; k++) begin
				ds_v_sd[k] <= ds_v_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= DIV_BITS; k++) begin
				ds_cmd_sd[k] <= ds_cmd_in[k];
				for (int j = 0; j < LANES; j++) begin
					ds_ln_sd[k][j] <= ircf_pkg::div_step(ds_ln_in[k][j],
						ds_cmd_in[k].value[Z_W-1:0]);
				end
			end
		end
	end

	// ---------------- corner stage ----------------
	logic              v_sc;
	ircf_pkg::cmd_t    cmd_sc;
	logic [SIZE_W-1:0] corner_sc [LANES];
	logic [SIZE_W-1:0] half_w;
	logic [SIZE_W-1:0] half_h;
	ircf_pkg::lanes_t  q_fin;

	assign q_fin  = ds_ln_sd[DIV_BITS];
	assign half_w = {1'b0, ds_cmd_sd[DIV_BITS].w[SIZE_W-1:1]};
	assign half_h = {1'b0, ds_cmd_sd[DIV_BITS].h[SIZE_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sc <= ds_v_sd[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_sc <= ds_cmd_sd[DIV_BITS];
			corner_sc[ircf_pkg::LANE_X1] <= half_w - {1'b0, q_fin[ircf_pkg::LANE_X1].dq};
			corner_sc[ircf_pkg::LANE_Y1] <= half_h - {1'b0, q_fin[ircf_pkg::LANE_Y1].dq};
			corner_sc[ircf_pkg::LANE_X2] <= half_w + {1'b0, q_fin[ircf_pkg::LANE_X2].dq};
			corner_sc[ircf_pkg::LANE_Y2] <= half_h + {1'b0, q_fin[ircf_pkg::LANE_Y2].dq};
		end
	end

	// ---------------- frame assembly stage ----------------
	logic [7:0]        body   [FRAME_MAX];
	logic [BODY_W-1:0] blen;
	logic [7:0]        psum_a;
	logic [7:0]        psum_b;

	always_comb begin
		for (int i = 0; i < FRAME_MAX; i++) begin
			body[i] = '0;
		end
		blen    = '0;
		body[0] = ircf_pkg::FRAME_HEAD;
		body[1] = ircf_pkg::LEN_SHORT;
		body[2] = ircf_pkg::FRAME_PREFIX;
		body[5] = cmd_sc.value[7:0];
		case (cmd_sc.mode)
			ircf_pkg::MODE_CORRECT: begin
				body[3] = ircf_pkg::CMD_CORRECT;
				body[4] = ircf_pkg::OP_TWO;
				blen    = ircf_pkg::BODY_SHORT;
			end
			ircf_pkg::MODE_BRIGHT: begin
				body[1] = ircf_pkg::LEN_BRIGHT;
				body[3] = ircf_pkg::CMD_BRIGHT;
				body[4] = ircf_pkg::OP_ONE;
				body[6] = cmd_sc.value[15:8];
				blen    = ircf_pkg::BODY_BRIGHT;
			end
			ircf_pkg::MODE_OP_ONE: begin
				body[3] = cmd_sc.cmd;
				body[4] = ircf_pkg::OP_ONE;
				blen    = ircf_pkg::BODY_SHORT;
			end
			ircf_pkg::MODE_OP_TWO: begin
				body[3] = cmd_sc.cmd;
				body[4] = ircf_pkg::OP_TWO;
				blen    = ircf_pkg::BODY_SHORT;
			end
			ircf_pkg::MODE_PALETTE: begin
				body[3] = ircf_pkg::CMD_PALETTE;
				body[4] = ircf_pkg::OP_TWO;
				blen    = ircf_pkg::BODY_SHORT;
			end
			ircf_pkg::MODE_ZOOM: begin
				body[1] = ircf_pkg::LEN_ZOOM;
				body[3] = ircf_pkg::CMD_ZOOM;
				body[4] = ircf_pkg::OP_TWO;
				// corners little-endian: x1 y1 x2 y2
				for (int j = 0; j < LANES; j++) begin
					body[5 + 2*j] = corner_sc[j][7:0];
					body[6 + 2*j] = 8'(corner_sc[j][SIZE_W-1:8]);
				end
				blen = ircf_pkg::BODY_ZOOM;
			end
			default: ;
		endcase
		// checksum split in two halves, finished at the serializer load
		psum_a = '0;
		psum_b = '0;
		for (int i = 0; i < SPLIT; i++) begin
			psum_a = psum_a + body[i];
		end
		for (int i = SPLIT; i < BODY_MAX; i++) begin
			psum_b = psum_b + body[i];
		end
	end

	logic              v_sf;
	logic              emit_sf;
	logic [7:0]        body_sf [BODY_MAX];
	logic [BODY_W-1:0] blen_sf;
	logic [7:0]        psum_a_sf;
	logic [7:0]        psum_b_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (adv) begin
			v_sf <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_sf   <= cmd_sc.emit;
			blen_sf   <= blen;
			psum_a_sf <= psum_a;
			psum_b_sf <= psum_b;
			for (int i = 0; i < BODY_MAX; i++) begin
				body_sf[i] <= body[i];
			end
		end
	end

	// ---------------- byte serializer ----------------
	logic [7:0]       frame     [FRAME_MAX];
	logic [7:0]       csum;
	logic [CNT_W-1:0] pos_sum;
	logic [7:0]       buf_q     [FRAME_MAX];
	logic [CNT_W-1:0] cnt_q;
	logic             load;

	assign pos_sum = {1'b0, blen_sf};
	assign csum    = psum_a_sf + psum_b_sf;

	always_comb begin
		for (int i = 0; i < FRAME_MAX; i++) begin
			frame[i] = 8'h00;
		end
		for (int i = 0; i < BODY_MAX; i++) begin
			frame[i] = body_sf[i];
		end
		for (int i = 0; i < FRAME_MAX; i++) begin
			if (CNT_W'(i) == pos_sum) begin
				frame[i] = csum;
			end else if (CNT_W'(i) == pos_sum + CNT_W'(1)) begin
				frame[i] = ircf_pkg::FRAME_TAIL0;
			end else if (CNT_W'(i) == pos_sum + CNT_W'(2)) begin
				frame[i] = ircf_pkg::FRAME_TAIL1;
			end
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign frame_byte = buf_q[0];
	assign last       = (cnt_q == CNT_W'(1));
	assign pop        = out_valid & out_ready;
	assign load_ok    = !out_valid || (out_ready && last);
	assign load       = v_sf && emit_sf && load_ok;
	// a slot with no frame drains without waiting on the serializer
	assign adv        = !v_sf || !emit_sf || load_ok;
	assign in_ready   = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pos_sum + ircf_pkg::TAIL_BYTES;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < FRAME_MAX; i++) begin
				buf_q[i] <= frame[i];
			end
		end else if (pop) begin
			for (int i = 0; i < FRAME_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[FRAME_MAX-1] <= '0;
		end
	end

endmodule

### src/ircf_checker.sv
// ----------------------------------------------------------------------------
// IR camera frame encoder checker
// Port-level properties of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ir_camera_command_frame_encoder_unit_assert.svh"

module ircf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  mode,
	input logic [7:0]  command_byte,
	input logic signed [15:0] value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_byte,
	input logic        last,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	logic        in_stall;
	logic        out_stall;
	logic        cfg_wr;
	logic [11:0] wr_size;
	logic [11:0] rd_size;

	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign wr_size   = pwdata[11:0];
	assign rd_size   = prdata[11:0];

	// no bytes while reset is held
	`IRCF_ASSERT_IMP(a_quiet_in_reset, clk, 1'b0, !arst_n, !out_valid)

	// a stalled byte holds
	`IRCF_ASSERT_NXT(a_out_hold, clk, !arst_n, out_stall, out_valid && $stable({frame_byte, last}))

	// a stalled request holds
	`IRCF_ASSERT_NXT(a_in_hold, clk, !arst_n, in_stall, in_valid && $stable({mode, command_byte, value}))

	// every frame closes with the second tail byte
	`IRCF_ASSERT_IMP(a_tail_byte, clk, !arst_n, out_valid && last, frame_byte == ircf_pkg::FRAME_TAIL1)

	// a written register reads back
	`IRCF_ASSERT_IMP(a_cfg_readback, clk, !arst_n, cfg_wr ##1 $stable(paddr[2]), rd_size == $past(wr_size))

endmodule

bind ir_camera_command_frame_encoder_unit ircf_checker u_ircf_checker (.*);
